// ===== src/locd_pkg.sv =====
package locd_pkg;

   // graph size and derived widths
   localparam int NUM_LOCKS = 64;
   localparam int NODE_W    = $clog2(NUM_LOCKS);
   localparam int DEPTH_W   = $clog2(NUM_LOCKS + 1);
   localparam int LOCK_W    = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_START,
      ST_FETCH,
      ST_EXAM,
      ST_POP_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              found;
      logic [NODE_W-1:0] idx;
   } pick_type;

   // lowest set bit of a node mask
   function automatic pick_type first_set(input logic [NUM_LOCKS-1:0] mask);
      pick_type res;
      res.found = 1'b0;
      res.idx   = '0;
      for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            res.found = 1'b1;
            res.idx   = NODE_W'(i);
         end
      end
      return res;
   endfunction

endpackage

// ===== src/locd_if.sv =====
interface locd_req_if;
   logic                       valid;
   logic                       ready;
   logic [locd_pkg::LOCK_W-1:0] held_lock;
   logic [locd_pkg::LOCK_W-1:0] new_lock;

   modport source (output valid, output held_lock, output new_lock, input ready);
   modport sink   (input valid, input held_lock, input new_lock, output ready);
endinterface

interface locd_rsp_if;
   logic valid;
   logic ready;
   logic deadlock;

   modport source (output valid, output deadlock, input ready);
   modport sink   (input valid, input deadlock, output ready);
endinterface

// ===== src/lock_order_cycle_detector_core.sv =====
// Operation: the edge is merged into its row, then the search runs; each
// examination of a stack top goes through the adjacency read port, and each
// pop also reads the stack; the result beat then waits until it is taken.
// Throughput: one beat at a time; ready is high only while idle.
// Reset (synchronous): clears all edges through per-row valid bits, no sweep.
module lock_order_cycle_detector_core (
   input logic          clock,
   input logic          reset,
   locd_req_if.sink     req_chan,
   locd_rsp_if.source   rsp_chan
);

   localparam int N  = locd_pkg::NUM_LOCKS;
   localparam int NW = locd_pkg::NODE_W;
   localparam int DW = locd_pkg::DEPTH_W;

   locd_pkg::state_type state_ff, state_in;

   logic [NW-1:0] src_ff, src_in;
   logic [NW-1:0] dst_ff, dst_in;
   logic          edge_ok_ff, edge_ok_in;
   logic [N-1:0]  visited_ff, visited_in;
   logic [N-1:0]  on_path_ff, on_path_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [NW-1:0] top_ff, top_in;
   logic          deadlock_ff, deadlock_in;
   logic [N-1:0]  adj_vld_ff, adj_vld_in;

   // memories
   logic [N-1:0]  adj_mem [N];
   logic [NW-1:0] stack_mem [N];
   logic [N-1:0]  adj_rd_ff;
   logic          adj_rd_vld_ff;
   logic [NW-1:0] stk_rd_ff;

   logic [NW-1:0] adj_rd_addr;
   logic          adj_we;
   logic [N-1:0]  adj_wdata;
   logic [NW-1:0] stk_rd_addr;
   logic          stk_we;
   logic [NW-1:0] stk_waddr;
   logic [NW-1:0] stk_wdata;

   logic [N-1:0]       row;
   logic [N-1:0]       pe_in;
   locd_pkg::pick_type pick;

   // adjacency row as read, rows never written read as empty
   assign row = adj_rd_ff & {N{adj_rd_vld_ff}};

   // shared pick unit: next start or next unvisited neighbour
   assign pe_in = (state_ff == locd_pkg::ST_START) ? ~visited_ff : (row & ~visited_ff);
   assign pick  = locd_pkg::first_set(pe_in);

   assign req_chan.ready   = (state_ff == locd_pkg::ST_IDLE);
   assign rsp_chan.valid   = (state_ff == locd_pkg::ST_DONE);
   assign rsp_chan.deadlock = deadlock_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= locd_pkg::ST_IDLE;
         adj_vld_ff <= '0;
         depth_ff   <= '0;
         visited_ff <= '0;
         on_path_ff <= '0;
      end else begin
         state_ff   <= state_in;
         adj_vld_ff <= adj_vld_in;
         depth_ff   <= depth_in;
         visited_ff <= visited_in;
         on_path_ff <= on_path_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      edge_ok_ff  <= edge_ok_in;
      top_ff      <= top_in;
      deadlock_ff <= deadlock_in;
   end

   // adjacency memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[src_ff] <= adj_wdata;
      end
      adj_rd_ff     <= adj_mem[adj_rd_addr];
      adj_rd_vld_ff <= adj_vld_ff[adj_rd_addr];
   end

   // search stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stack_mem[stk_rd_addr];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      edge_ok_in  = edge_ok_ff;
      visited_in  = visited_ff;
      on_path_in  = on_path_ff;
      depth_in    = depth_ff;
      top_in      = top_ff;
      deadlock_in = deadlock_ff;
      adj_vld_in  = adj_vld_ff;
      adj_rd_addr = top_ff;
      adj_we      = 1'b0;
      adj_wdata   = row | (N'(1) << dst_ff);
      stk_rd_addr = '0;
      stk_we      = 1'b0;
      stk_waddr   = depth_ff[NW-1:0];
      stk_wdata   = pick.idx;

      case (state_ff)
         locd_pkg::ST_IDLE: begin
            // read the source row ahead of the merge
            adj_rd_addr = NW'(req_chan.held_lock);
            if (req_chan.valid) begin
               src_in     = NW'(req_chan.held_lock);
               dst_in     = NW'(req_chan.new_lock);
               edge_ok_in = (DW'(req_chan.held_lock) < DW'(N)) &&
                            (DW'(req_chan.new_lock) < DW'(N));
               state_in   = locd_pkg::ST_MERGE;
            end
         end

         locd_pkg::ST_MERGE: begin
            if (edge_ok_ff) begin
               adj_we             = 1'b1;
               adj_vld_in[src_ff] = 1'b1;
            end
            visited_in = '0;
            on_path_in = '0;
            depth_in   = '0;
            state_in   = locd_pkg::ST_START;
         end

         locd_pkg::ST_START: begin
            if (!pick.found) begin
               deadlock_in = 1'b0;
               state_in    = locd_pkg::ST_DONE;
            end else begin
               visited_in[pick.idx] = 1'b1;
               on_path_in[pick.idx] = 1'b1;
               stk_we   = 1'b1;
               depth_in = depth_ff + DW'(1);
               top_in   = pick.idx;
               state_in = locd_pkg::ST_FETCH;
            end
         end

         locd_pkg::ST_FETCH: begin
            adj_rd_addr = top_ff;
            state_in    = locd_pkg::ST_EXAM;
         end

         locd_pkg::ST_EXAM: begin
            if (|(row & on_path_ff)) begin
               // back edge onto the path: cycle
               deadlock_in = 1'b1;
               depth_in    = '0;
               state_in    = locd_pkg::ST_DONE;
            end else if (pick.found) begin
               visited_in[pick.idx] = 1'b1;
               on_path_in[pick.idx] = 1'b1;
               if (depth_ff < DW'(N)) begin
                  stk_we   = 1'b1;
                  depth_in = depth_ff + DW'(1);
               end
               top_in   = pick.idx;
               state_in = locd_pkg::ST_FETCH;
            end else begin
               // dead end: pop
               on_path_in[top_ff] = 1'b0;
               depth_in    = depth_ff - DW'(1);
               stk_rd_addr = NW'(depth_ff - DW'(2));
               if (depth_ff == DW'(1)) begin
                  state_in = locd_pkg::ST_START;
               end else begin
                  state_in = locd_pkg::ST_POP_WAIT;
               end
            end
         end

         locd_pkg::ST_POP_WAIT: begin
            top_in   = stk_rd_ff;
            state_in = locd_pkg::ST_FETCH;
         end

         locd_pkg::ST_DONE: begin
            if (rsp_chan.ready) begin
               state_in = locd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = locd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/locd_checker.sv =====
module locd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_deadlock
);

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_deadlock))
      else $error("result beat dropped or changed while stalled");

   // never idle while a result waits
   a_busy_with_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while a result is pending");

   // an accepted beat starts a search, no instant result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("block not busy after accepting a beat");

   // result taken returns the block to idle
   a_rsp_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("block not idle after result taken");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

bind lock_order_cycle_detector_core locd_checker u_locd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_deadlock (rsp_chan.deadlock)
);

// ===== tb/sv/tb_lock_order_cycle_detector_core.sv =====
module tb_lock_order_cycle_detector_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either side
   localparam int SETTLE_WAIT  = 500;   // > worst-case search latency
   localparam int RESET_CYCLES = 6;

   typedef enum int {
      IDLE_SEND,   // sender idles 20%, receiver 52%
      IDLE_RECV,   // sender idles 52%, receiver 20%
      IDLE_NONE    // both sides at full rate
   } idle_mode_type;

   typedef struct {
      logic [locd_pkg::LOCK_W-1:0] held;
      logic [locd_pkg::LOCK_W-1:0] taken;
      idle_mode_type               mode;
      bit                          drain;   // hold this beat until all answers are in
   } lock_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   locd_req_if req_if ();
   locd_rsp_if rsp_if ();

   lock_order_cycle_detector_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   // stimulus and scoreboard state
   lock_beat_type                  pending_beats[$];
   lock_beat_type                  placed_edges[$];
   bit                             deadlock_due[$];
   logic [locd_pkg::NUM_LOCKS-1:0] order_rows[locd_pkg::NUM_LOCKS];
   int                             rank_order[locd_pkg::NUM_LOCKS];
   int                             recv_idle_pct = 0;
   int                             mismatch_count = 0;
   int                             quiet_cycles = 0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic int sender_gap_pct(input idle_mode_type m);
      case (m)
         IDLE_SEND: return 20;
         IDLE_RECV: return 52;
         default:   return 0;
      endcase
   endfunction

   function automatic int receiver_gap_pct(input idle_mode_type m);
      case (m)
         IDLE_SEND: return 52;
         IDLE_RECV: return 20;
         default:   return 0;
      endcase
   endfunction

   // depth-first search over the lock-order graph; true on any directed cycle
   function automatic bit graph_has_loop();
      logic [locd_pkg::NUM_LOCKS-1:0] seen;
      logic [locd_pkg::NUM_LOCKS-1:0] on_path;
      logic [locd_pkg::NUM_LOCKS-1:0] cand;
      int                             stk[locd_pkg::NUM_LOCKS];
      int                             sp;
      int                             top;
      int                             nxt;
      seen    = '0;
      on_path = '0;
      for (int s = 0; s < locd_pkg::NUM_LOCKS; s++) begin
         if (!seen[s]) begin
            seen[s]    = 1'b1;
            on_path[s] = 1'b1;
            stk[0]     = s;
            sp         = 1;
            while (sp > 0) begin
               top = stk[sp-1];
               if ((order_rows[top] & on_path) != '0)
                  return 1'b1;
               cand = order_rows[top] & ~seen;
               if (cand != '0) begin
                  // lowest-numbered unvisited neighbor
                  nxt = 0;
                  for (int b = locd_pkg::NUM_LOCKS - 1; b >= 0; b--)
                     if (cand[b]) nxt = b;
                  seen[nxt]    = 1'b1;
                  on_path[nxt] = 1'b1;
                  stk[sp]      = nxt;
                  sp++;
               end else begin
                  on_path[top] = 1'b0;
                  sp--;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   // insert the accepted edge, then record the expected answer
   task automatic predict_deadlock(input logic [locd_pkg::LOCK_W-1:0] held,
                                   input logic [locd_pkg::LOCK_W-1:0] taken);
      if (held < locd_pkg::NUM_LOCKS && taken < locd_pkg::NUM_LOCKS)
         order_rows[held][taken] = 1'b1;
      deadlock_due.insert(deadlock_due.size(), graph_has_loop());
   endtask

   task automatic queue_beat(input int held, input int taken,
                             input idle_mode_type m, input bit drain);
      lock_beat_type b;
      b.held  = locd_pkg::LOCK_W'(held);
      b.taken = locd_pkg::LOCK_W'(taken);
      b.mode  = m;
      b.drain = drain;
      pending_beats.insert(pending_beats.size(), b);
      placed_edges.insert(placed_edges.size(), b);
   endtask

   // edge between two positions of the topological order
   task automatic queue_forward(input int i, input int j,
                                input idle_mode_type m, input bit drain);
      queue_beat(rank_order[i], rank_order[j], m, drain);
   endtask

   // random edge that keeps the graph acyclic; chains and repeats favored
   task automatic queue_random_forward(input idle_mode_type m, input bit drain);
      lock_beat_type old;
      int            i;
      int            j;
      if (placed_edges.size() != 0 && $urandom_range(99) < 12) begin
         old = placed_edges[$urandom_range(placed_edges.size() - 1)];
         queue_beat(old.held, old.taken, m, drain);
      end else begin
         i = $urandom_range(locd_pkg::NUM_LOCKS - 2);
         j = ($urandom_range(99) < 40) ? i + 1 :
             $urandom_range(locd_pkg::NUM_LOCKS - 1, i + 1);
         queue_forward(i, j, m, drain);
      end
   endtask

   task automatic place_node(input int node, input int pos);
      int tmp;
      for (int k = 0; k < locd_pkg::NUM_LOCKS; k++) begin
         if (rank_order[k] == node) begin
            tmp             = rank_order[pos];
            rank_order[pos] = node;
            rank_order[k]   = tmp;
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive_beats
      lock_beat_type head;
      bit            hold;
      bit            present;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         hold = req_if.valid && !req_if.ready;
         if (req_if.valid && req_if.ready) begin
            predict_deadlock(req_if.held_lock, req_if.new_lock);
            head = pending_beats.pop_front();
         end
         if (!hold) begin
            present = 1'b0;
            if (pending_beats.size() != 0) begin
               head          = pending_beats[0];
               recv_idle_pct = receiver_gap_pct(head.mode);
               if (!(head.drain && deadlock_due.size() != 0) &&
                   $urandom_range(99) >= sender_gap_pct(head.mode))
                  present = 1'b1;
            end
            req_if.valid <= present;
            if (present) begin
               req_if.held_lock <= head.held;
               req_if.new_lock  <= head.taken;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : check_answers
      bit want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (deadlock_due.size() == 0) begin
               report_mismatch($sformatf("deadlock=%0b with no answer pending",
                                         rsp_if.deadlock));
            end else begin
               want = deadlock_due.pop_front();
               if (rsp_if.deadlock !== want)
                  report_mismatch($sformatf("deadlock=%0b, predicted %0b",
                                            rsp_if.deadlock, want));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_test
      int r;
      int tmp;
      req_if.valid     = 1'b0;
      req_if.held_lock = '0;
      req_if.new_lock  = '0;
      rsp_if.ready     = 1'b0;
      for (int u = 0; u < locd_pkg::NUM_LOCKS; u++)
         order_rows[u] = '0;

      // random topological order; locks 0 and 63 kept away from its ends
      for (int k = 0; k < locd_pkg::NUM_LOCKS; k++)
         rank_order[k] = k;
      for (int k = locd_pkg::NUM_LOCKS - 1; k > 0; k--) begin
         r             = $urandom_range(k);
         tmp           = rank_order[k];
         rank_order[k] = rank_order[r];
         rank_order[r] = tmp;
      end
      place_node(0, 20);
      place_node(locd_pkg::NUM_LOCKS - 1, 40);

      // directed: extreme lock numbers, repeats, chains, fan-out and fan-in
      queue_forward(0, 63, IDLE_SEND, 1'b0);
      queue_forward(0, 20, IDLE_SEND, 1'b0);
      queue_forward(20, 40, IDLE_SEND, 1'b0);
      queue_forward(40, 63, IDLE_SEND, 1'b0);
      queue_forward(20, 40, IDLE_SEND, 1'b0);
      queue_forward(10, 11, IDLE_SEND, 1'b0);
      queue_forward(11, 12, IDLE_SEND, 1'b0);
      queue_forward(12, 13, IDLE_SEND, 1'b0);
      queue_forward(1, 2, IDLE_SEND, 1'b0);
      queue_forward(1, 5, IDLE_SEND, 1'b0);
      queue_forward(1, 62, IDLE_SEND, 1'b0);
      queue_forward(30, 50, IDLE_SEND, 1'b0);
      queue_forward(45, 50, IDLE_SEND, 1'b0);
      queue_forward(20, 63, IDLE_SEND, 1'b0);
      queue_forward(5, 40, IDLE_SEND, 1'b0);
      queue_forward(0, 63, IDLE_SEND, 1'b0);

      // random acyclic growth under three idling patterns
      for (int n = 0; n < 540; n++)
         queue_random_forward(IDLE_SEND, 1'b0);
      for (int n = 0; n < 540; n++)
         queue_random_forward(IDLE_RECV, n == 0);
      for (int n = 0; n < 500; n++)
         queue_random_forward(IDLE_NONE, n == 0);

      // close a long cycle, then self-loops and arbitrary edges
      queue_forward(63, 0, IDLE_NONE, 1'b1);
      queue_beat(0, 0, IDLE_SEND, 1'b0);
      queue_beat(locd_pkg::NUM_LOCKS - 1, locd_pkg::NUM_LOCKS - 1, IDLE_SEND, 1'b0);
      for (int n = 0; n < 40; n++)
         queue_beat($urandom_range(locd_pkg::NUM_LOCKS - 1),
                    $urandom_range(locd_pkg::NUM_LOCKS - 1), IDLE_SEND, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || deadlock_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (deadlock_due.size() != 0)
         report_mismatch($sformatf("%0d answers never arrived", deadlock_due.size()));
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
